@@ src/ask_pkg.sv @@
// ask_pkg: shared types, constants and helper functions for the Ackermann
// steering kinematics pipeline.
// No dependencies.
package ask_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEELBASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEER = 1'b1;

  localparam logic [30:0] WHEELBASE_RST = 31'd65536;
  localparam logic [16:0] MAX_STEER_RST = 17'd32768;

  localparam int XY_W      = 44;  // CORDIC x/y, inverse vectors stay below 2^42
  localparam int Z_W       = 34;  // CORDIC angle accumulator, Q4.30
  localparam int DIV_STEPS = 32;  // quotient bits per divider

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // atan(2^-i) in Q2.30, rounded to nearest
  localparam logic [31:0] ATAN_TAB [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LATERAL = 2'd1,
    ST_ROTATE  = 2'd2,
    ST_LIMIT   = 2'd3
  } status_t;

  // per-transaction control that rides along the pipeline
  typedef struct packed {
    logic               inv;    // inverse action
    logic               kill;   // error or all-zero result
    logic               zflag;  // zero steer (forward) or zero yaw (inverse)
    logic               neg;    // sign of the value being divided / angle
    logic               ovf;    // quotient overflows 32 bits
    logic               fixv;   // tan already known, skip the quotient
    status_t            status;
    logic signed [31:0] speed;
    logic signed [31:0] val;    // steer in, then angle or tan
  } ctl_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cor_t;

  typedef struct packed {
    logic [31:0] r;
    logic [31:0] low;
    logic [31:0] q;
    logic [31:0] d;
  } div_t;

  // one restoring division step
  function automatic div_t div_step(input div_t a);
    logic [32:0] t;
    div_t        o;
    t     = {a.r, a.low[31]};
    o     = a;
    o.low = {a.low[30:0], 1'b0};
    if (t >= {1'b0, a.d}) begin
      o.r = 32'(t - {1'b0, a.d});
      o.q = {a.q[30:0], 1'b1};
    end else begin
      o.r = t[31:0];
      o.q = {a.q[30:0], 1'b0};
    end
    return o;
  endfunction

  // signed, saturated quotient from magnitude and sign
  function automatic logic signed [31:0] sat_quot(input logic neg, input logic ovf,
                                                  input logic [31:0] q);
    logic signed [31:0] res;
    if (!neg) begin
      res = (ovf || q[31]) ? Q_MAX : $signed(q);
    end else begin
      res = (ovf || q > 32'h8000_0000) ? Q_MIN : $signed(-q);
    end
    return res;
  endfunction

endpackage

@@ src/ask_if.sv @@
// ask_in_if / ask_out_if: valid-ready channels for command and result
// transactions. Depends on nothing.
interface ask_in_if;
  logic               valid;
  logic               ready;
  logic               action;
  logic signed [31:0] speed;
  logic signed [31:0] lateral_speed;
  logic signed [31:0] yaw_rate;
  logic signed [17:0] steer_angle;

  modport source(output valid, action, speed, lateral_speed, yaw_rate, steer_angle,
                 input ready);
  modport sink(input valid, action, speed, lateral_speed, yaw_rate, steer_angle,
               output ready);
endinterface

interface ask_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] out_speed;
  logic signed [17:0] out_steer;
  logic signed [31:0] out_yaw_rate;

  modport source(output valid, status, out_speed, out_steer, out_yaw_rate,
                 input ready);
  modport sink(input valid, status, out_speed, out_steer, out_yaw_rate,
               output ready);
endinterface

@@ src/ackermann_steering_kinematics.sv @@
// Ackermann (bicycle model) kinematics: forward command to twist and
// inverse twist to steering angle. Depends on ask_pkg and ask_if.
//
// Usage:
//  - in_ch carries one command per transaction (valid/ready). action 0 turns
//    speed and steer_angle into a yaw rate, action 1 turns speed,
//    lateral_speed and yaw_rate into a steering angle.
//  - out_ch returns exactly one result transaction per command, in order.
//  - cfg_we/cfg_idx/cfg_wdata write the wheelbase (0) and max_steer (1); write
//    them only while no transaction is in flight.
//  - From acceptance to out_ch.valid a command passes the input multiply,
//    two normalise stages, one CORDIC stage per iteration, two 32-stage
//    restoring dividers (tan = y/x, yaw = speed*tan/wheelbase) and a
//    multiply between them.
//  - Throughput is one transaction per cycle while out_ch does not stall; every stage holds one item.
//  - When out_ch stalls with a result waiting, the whole pipeline holds and
//    in_ch.ready drops; nothing is lost or repeated.
//  - Reset clears all valid bits and loads wheelbase = 1.0 m and
//    max_steer = 0.5 rad.
module ackermann_steering_kinematics #(
  parameter int ANGLE_ITERATIONS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ask_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [ask_pkg::CFG_DATA_W-1:0] cfg_wdata,
  ask_in_if.sink                         in_ch,
  ask_out_if.source                      out_ch
);
  import ask_pkg::*;

  localparam int NI = ANGLE_ITERATIONS;

  // configuration
  logic [30:0] wb_r;
  logic [16:0] ms_r;
  logic [30:0] ewb;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r <= WHEELBASE_RST;
      ms_r <= MAX_STEER_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_WHEELBASE: wb_r <= cfg_wdata;
        CFG_MAX_STEER: ms_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign ewb = (wb_r == '0) ? 31'd1 : wb_r;

  // global stall
  logic adv;
  logic out_valid_r;
  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  // ---- input decode and multiply ----
  logic [31:0] a_yaw, a_spd;
  logic [17:0] a_str;
  ctl_t        c1_nxt;
  logic [62:0] num1_nxt;
  logic [47:0] den1_nxt;

  always_comb begin
    a_yaw    = in_ch.yaw_rate[31] ? 32'(-in_ch.yaw_rate) : 32'(in_ch.yaw_rate);
    a_spd    = in_ch.speed[31] ? 32'(-in_ch.speed) : 32'(in_ch.speed);
    a_str    = in_ch.steer_angle[17] ? 18'(-in_ch.steer_angle) : 18'(in_ch.steer_angle);
    num1_nxt = 63'(ewb) * 63'(a_yaw);
    den1_nxt = {a_spd, 16'b0};
    c1_nxt        = '0;
    c1_nxt.inv    = in_ch.action;
    c1_nxt.speed  = in_ch.speed;
    c1_nxt.status = ST_OK;
    if (!in_ch.action) begin
      c1_nxt.val   = 32'(in_ch.steer_angle);
      c1_nxt.zflag = (in_ch.steer_angle == '0);
      if (a_str > {1'b0, ms_r}) begin
        c1_nxt.kill   = 1'b1;
        c1_nxt.status = ST_LIMIT;
      end
    end else begin
      c1_nxt.zflag = (in_ch.yaw_rate == '0);
      c1_nxt.neg   = in_ch.yaw_rate[31] ^ in_ch.speed[31];
      if (in_ch.lateral_speed != '0) begin
        c1_nxt.kill   = 1'b1;
        c1_nxt.status = ST_LATERAL;
      end else if (in_ch.speed == '0) begin
        c1_nxt.kill   = 1'b1;
        c1_nxt.status = (in_ch.yaw_rate == '0) ? ST_OK : ST_ROTATE;
      end
    end
  end

  logic        v1_r;
  ctl_t        c1_r;
  logic [62:0] num1_r;
  logic [47:0] den1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (adv) v1_r <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_r   <= c1_nxt;
      num1_r <= num1_nxt;
      den1_r <= den1_nxt;
    end
  end

  // ---- normalise: shift count so both magnitudes drop below 2^40 ----
  logic [62:0] w1;
  logic [4:0]  s2_nxt;
  always_comb begin
    w1     = num1_r | {15'b0, den1_r};
    s2_nxt = '0;
    for (int b = 40; b < 63; b++) begin
      if (w1[b]) s2_nxt = 5'(b - 39);
    end
  end

  logic        v2_r;
  ctl_t        c2_r;
  logic [62:0] num2_r;
  logic [47:0] den2_r;
  logic [4:0]  s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (adv) v2_r <= v1_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r   <= c1_r;
      num2_r <= num1_r;
      den2_r <= den1_r;
      s2_r   <= s2_nxt;
    end
  end

  // ---- CORDIC start vector ----
  logic [62:0] sh_num;
  logic [47:0] sh_den;
  cor_t        d3_nxt;
  always_comb begin
    sh_num = num2_r >> s2_r;
    sh_den = den2_r >> s2_r;
    if (c2_r.inv) begin
      d3_nxt.x = {4'b0, sh_den[39:0]};
      d3_nxt.y = {4'b0, sh_num[39:0]};
      d3_nxt.z = '0;
    end else begin
      d3_nxt.x = XY_W'(1) <<< 29;
      d3_nxt.y = '0;
      d3_nxt.z = {{2{c2_r.val[31]}}, c2_r.val} <<< 14;
    end
  end

  logic cv [NI+1];
  ctl_t cc [NI+1];
  cor_t cd [NI+1];

  logic v3_r;
  ctl_t c3_r;
  cor_t d3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (adv) v3_r <= v2_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c3_r <= c2_r;
      d3_r <= d3_nxt;
    end
  end
  assign cv[0] = v3_r;
  assign cc[0] = c3_r;
  assign cd[0] = d3_r;

  // ---- CORDIC: rotation for forward, vectoring for inverse ----
  for (genvar k = 0; k < NI; k++) begin : g_cor
    logic                   ccw;
    logic signed [Z_W-1:0]  at;
    cor_t                   n_nxt;
    logic                   v_r;
    ctl_t                   c_r;
    cor_t                   n_r;

    always_comb begin
      ccw = cc[k].inv ? (cd[k].y < 0) : (cd[k].z >= 0);
      at  = {2'b00, ATAN_TAB[k]};
      if (ccw) begin
        n_nxt.x = cd[k].x - (cd[k].y >>> k);
        n_nxt.y = cd[k].y + (cd[k].x >>> k);
        n_nxt.z = cd[k].z - at;
      end else begin
        n_nxt.x = cd[k].x + (cd[k].y >>> k);
        n_nxt.y = cd[k].y - (cd[k].x >>> k);
        n_nxt.z = cd[k].z + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (adv) v_r <= cv[k];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_r <= cc[k];
        n_r <= n_nxt;
      end
    end
    assign cv[k+1] = v_r;
    assign cc[k+1] = c_r;
    assign cd[k+1] = n_r;
  end

  // ---- angle finish (inverse) and tan divider set-up (forward) ----
  logic signed [Z_W-1:0] zr;
  logic signed [Z_W-1:0] zq;
  logic [17:0]           rmag;
  logic [31:0]           ay;
  ctl_t                  c4_nxt;
  div_t                  q4_nxt;

  always_comb begin
    zr     = cd[NI].z + Z_W'(8192);
    zq     = zr >>> 14;
    rmag   = (zq < 0 || cc[NI].zflag) ? 18'd0 : zq[17:0];
    ay     = cd[NI].y[XY_W-1] ? 32'(-cd[NI].y) : 32'(cd[NI].y);
    c4_nxt = cc[NI];
    if (cc[NI].inv) begin
      c4_nxt.val = cc[NI].neg ? 32'(-$signed({14'b0, rmag})) : {14'b0, rmag};
      if (!cc[NI].kill && rmag > {1'b0, ms_r}) begin
        c4_nxt.kill   = 1'b1;
        c4_nxt.status = ST_LIMIT;
      end
    end else begin
      c4_nxt.neg = cd[NI].y < 0;
      if (cc[NI].zflag) begin
        c4_nxt.fixv = 1'b1;
        c4_nxt.val  = '0;
      end else if (cd[NI].x <= 0) begin
        c4_nxt.fixv = 1'b1;
        c4_nxt.val  = (cd[NI].y > 0) ? Q_MAX : ((cd[NI].y < 0) ? -Q_MAX : 32'sd0);
      end
    end
    q4_nxt.r   = {16'b0, ay[31:16]};
    q4_nxt.low = {ay[15:0], 16'b0};
    q4_nxt.q   = '0;
    q4_nxt.d   = cd[NI].x[31:0];
    c4_nxt.ovf = ({16'b0, ay[31:16]} >= cd[NI].x[31:0]);
  end

  logic dv [DIV_STEPS+1];
  ctl_t dc [DIV_STEPS+1];
  div_t dd [DIV_STEPS+1];

  logic v4_r;
  ctl_t c4_r;
  div_t q4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (adv) v4_r <= cv[NI];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      c4_r <= c4_nxt;
      q4_r <= q4_nxt;
    end
  end
  assign dv[0] = v4_r;
  assign dc[0] = c4_r;
  assign dd[0] = q4_r;

  // ---- divider for tan = (y << 16) / x ----
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div1
    logic v_r;
    ctl_t c_r;
    div_t q_r;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (adv) v_r <= dv[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_r <= dc[j];
        q_r <= div_step(dd[j]);
      end
    end
    assign dv[j+1] = v_r;
    assign dc[j+1] = c_r;
    assign dd[j+1] = q_r;
  end

  // ---- tan saturate ----
  ctl_t ct_nxt;
  always_comb begin
    ct_nxt = dc[DIV_STEPS];
    if (!dc[DIV_STEPS].inv && !dc[DIV_STEPS].fixv) begin
      ct_nxt.val = sat_quot(dc[DIV_STEPS].neg, dc[DIV_STEPS].ovf, dd[DIV_STEPS].q);
    end
  end

  logic vt_r;
  ctl_t ct_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vt_r <= 1'b0;
    else if (adv) vt_r <= dv[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) ct_r <= ct_nxt;
  end

  // ---- speed * tan ----
  logic               vm_r;
  ctl_t               cm_r;
  logic signed [63:0] pm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (adv) vm_r <= vt_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      cm_r <= ct_r;
      pm_r <= 64'(ct_r.speed) * 64'(ct_r.val);
    end
  end

  // ---- yaw divider set-up ----
  logic [63:0] ap;
  ctl_t        ce_nxt;
  div_t        qe_nxt;
  always_comb begin
    ap          = pm_r[63] ? 64'(-pm_r) : 64'(pm_r);
    ce_nxt      = cm_r;
    ce_nxt.neg  = pm_r[63];
    ce_nxt.ovf  = ap[63:32] >= {1'b0, ewb};
    qe_nxt.r    = ap[63:32];
    qe_nxt.low  = ap[31:0];
    qe_nxt.q    = '0;
    qe_nxt.d    = {1'b0, ewb};
  end

  logic ev [DIV_STEPS+1];
  ctl_t ec [DIV_STEPS+1];
  div_t ed [DIV_STEPS+1];

  logic ve_r;
  ctl_t ce_r;
  div_t qe_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else if (adv) ve_r <= vm_r;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      ce_r <= ce_nxt;
      qe_r <= qe_nxt;
    end
  end
  assign ev[0] = ve_r;
  assign ec[0] = ce_r;
  assign ed[0] = qe_r;

  // ---- divider for yaw = speed * tan / wheelbase ----
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div2
    logic v_r;
    ctl_t c_r;
    div_t q_r;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r <= 1'b0;
      else if (adv) v_r <= ev[j];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        c_r <= ec[j];
        q_r <= div_step(ed[j]);
      end
    end
    assign ev[j+1] = v_r;
    assign ec[j+1] = c_r;
    assign ed[j+1] = q_r;
  end

  // ---- output register ----
  ctl_t               cf;
  logic signed [31:0] yaw_q;
  logic [1:0]         status_nxt;
  logic signed [31:0] speed_nxt;
  logic signed [17:0] steer_nxt;
  logic signed [31:0] yaw_nxt;

  always_comb begin
    cf         = ec[DIV_STEPS];
    yaw_q      = sat_quot(cf.neg, cf.ovf, ed[DIV_STEPS].q);
    status_nxt = cf.status;
    speed_nxt  = cf.kill ? 32'sd0 : cf.speed;
    steer_nxt  = (cf.inv && !cf.kill) ? cf.val[17:0] : 18'sd0;
    yaw_nxt    = (!cf.inv && !cf.kill) ? yaw_q : 32'sd0;
  end

  logic [1:0]         status_r;
  logic signed [31:0] speed_r;
  logic signed [17:0] steer_r;
  logic signed [31:0] yaw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= ev[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      speed_r  <= speed_nxt;
      steer_r  <= steer_nxt;
      yaw_r    <= yaw_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.out_speed    = speed_r;
  assign out_ch.out_steer    = steer_r;
  assign out_ch.out_yaw_rate = yaw_r;

endmodule
